/* hw/rtl/lea_pkg.sv */
// ----------------------------------------------------------------------------
// lea_pkg
// Shared widths, character codes and byte classification for the line edit
// assembler.
// ----------------------------------------------------------------------------
package lea_pkg;

    localparam int DATA_W         = 8;
    localparam int LEN_W          = 7;
    localparam int LINE_DEPTH_DEF = 64;

    localparam logic [DATA_W-1:0] CH_BACKSPACE   = 8'd8;
    localparam logic [DATA_W-1:0] CH_LF          = 8'd10;
    localparam logic [DATA_W-1:0] CH_CR          = 8'd13;
    localparam logic [DATA_W-1:0] CH_FIRST_PRINT = 8'd32;
    localparam logic [DATA_W-1:0] CH_DEL         = 8'd127;

    typedef logic [1:0] t_byte_class;

    localparam t_byte_class CLS_NONE  = 2'd0;
    localparam t_byte_class CLS_PRINT = 2'd1;
    localparam t_byte_class CLS_BS    = 2'd2;
    localparam t_byte_class CLS_EOL   = 2'd3;

    function automatic t_byte_class classify(input logic [DATA_W-1:0] c);
        t_byte_class cls;
        if (c >= CH_FIRST_PRINT && c < CH_DEL) begin
            cls = CLS_PRINT;
        end else if (c == CH_BACKSPACE) begin
            cls = CLS_BS;
        end else if (c == CH_LF || c == CH_CR) begin
            cls = CLS_EOL;
        end else begin
            cls = CLS_NONE;
        end
        return cls;
    endfunction

endpackage

/* hw/rtl/lea_line_ram.sv */
// ----------------------------------------------------------------------------
// lea_line_ram
// Line store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lea_line_ram #(
    parameter int DEPTH = lea_pkg::LINE_DEPTH_DEF,
    parameter int AW    = 6
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [lea_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic [lea_pkg::DATA_W-1:0] o_rdata
);
    import lea_pkg::*;

    logic [DATA_W-1:0] r_mem [0:DEPTH-1];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/line_edit_assembler_top.sv */
// An input byte is absorbed in the cycle it is taken; ready stays high outside readout.
// A line end with N stored bytes (N nonzero, delivery enabled) starts a readout: each result
// passes the registered RAM read, then a single output register; only one read is in flight.
// Input is held off while the reads are issued during readout; the last result may still wait.
// Reset: fill count cleared, deliver_enable set to 1, line RAM contents left as they are.
// ----------------------------------------------------------------------------
// line_edit_assembler_top
// Collects printable received bytes into a line RAM with backspace editing and
// streams a completed, non-empty line out on CR or LF while delivery is enabled.
// ----------------------------------------------------------------------------
module line_edit_assembler_top #(
    parameter int LINE_DEPTH = lea_pkg::LINE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [lea_pkg::DATA_W-1:0] i_rx_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [lea_pkg::DATA_W-1:0] o_line_byte,
    output logic                       o_line_last,
    output logic [lea_pkg::LEN_W-1:0]  o_line_length
);
    import lea_pkg::*;

    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CW = $clog2(LINE_DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic              r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_len, n_len;
    logic [AW-1:0]     r_rd_idx, n_rd_idx;
    logic              r_pend, n_pend;
    logic              r_pend_last, n_pend_last;
    logic              r_deliver_en;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_byte;
    logic              r_out_last;
    logic [CW-1:0]     r_out_len;

    logic              in_fire;
    logic              issue;
    logic              is_last_rd;
    logic              wr_en;
    t_byte_class       cls;
    logic [DATA_W-1:0] rd_data;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign cls        = classify(i_rx_byte);
    assign wr_en      = in_fire && (cls == CLS_PRINT) && (r_count < CW'(LINE_DEPTH));

    // one read in flight; the output register is free by the time data lands
    assign issue      = (r_state == ST_READ) && !r_pend && (!r_out_valid || i_out_ready);
    assign is_last_rd = (CW'(r_rd_idx) == r_len - CW'(1));

    lea_line_ram #(
        .DEPTH (LINE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_raddr (r_rd_idx),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_len       = r_len;
        n_rd_idx    = r_rd_idx;
        n_pend      = 1'b0;
        n_pend_last = r_pend_last;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (cls)
                        CLS_PRINT: begin
                            if (wr_en) begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        CLS_BS: begin
                            if (r_count != '0) begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        CLS_EOL: begin
                            if (r_count != '0 && r_deliver_en) begin
                                n_len    = r_count;
                                n_rd_idx = '0;
                                n_state  = ST_READ;
                            end
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (issue) begin
                    n_pend      = 1'b1;
                    n_pend_last = is_last_rd;
                    n_rd_idx    = r_rd_idx + AW'(1);
                    if (is_last_rd) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_pend       <= 1'b0;
            r_deliver_en <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            if (i_cfg_we) begin
                r_deliver_en <= i_cfg_wdata;
            end
            if (r_pend) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len       <= n_len;
        r_rd_idx    <= n_rd_idx;
        r_pend_last <= n_pend_last;
        if (r_pend) begin
            r_out_byte <= rd_data;
            r_out_last <= r_pend_last;
            r_out_len  <= r_len;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_line_byte   = r_out_byte;
    assign o_line_last   = r_out_last;
    assign o_line_length = LEN_W'(r_out_len);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LINE_DEPTH))
        else $error("line count above depth");

    a_read_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_count == '0))
        else $error("count not cleared during readout");

    a_pend_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (!r_out_valid || i_out_ready))
        else $error("read data arrives while output register is held");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_line_length != '0))
        else $error("emitted line with zero length");

endmodule
